@@ hdl/pmos_level1_companion_eval_core_macros.svh @@
// ----------------------------------------------------------------------------
// PMOS level-1 companion evaluator: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef PMOS_LEVEL1_COMPANION_EVAL_CORE_MACROS_SVH
`define PMOS_LEVEL1_COMPANION_EVAL_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PMCE_CHECK_NOW(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("pmce check failed");

// Next-cycle implication, disabled during reset
`define PMCE_CHECK_NEXT(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("pmce check failed");

`endif

@@ hdl/pmce_pkg.sv @@
// ----------------------------------------------------------------------------
// pmce_pkg
// Number format, codes, shared types and saturating helpers of the PMOS
// level-1 companion evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmce_pkg;

    // Fixed point word: signed, FRAC_BITS fraction bits
    localparam int FRAC_BITS = 32;
    localparam int WORD_BITS = 48;

    // Configuration port
    localparam int CFG_BITS     = 48;
    localparam int CFG_IDX_BITS = 2;
    localparam int VA_BITS      = 47;
    localparam int K_BITS       = 47;

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EARLY     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN      = 2'd2;

    // Operating region codes
    localparam logic [1:0] REGION_CUTOFF     = 2'd0;
    localparam logic [1:0] REGION_SATURATION = 2'd1;
    localparam logic [1:0] REGION_TRIODE     = 2'd2;

    // Shared unit operations
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // Shared unit sizing
    localparam int MUL_DIGIT = 16;
    localparam int MUL_STEPS = WORD_BITS / MUL_DIGIT;
    localparam int DIV_STEPS = WORD_BITS - 1;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);
    localparam int ACC_BITS  = 2 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

    // 0.1 V rounded to nearest, used for the start point
    localparam word_t ONE_TENTH =
        word_t'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    // Register defaults: Vt = 0.5 V, Va = 10 V, K = 1e-3 A/V^2
    localparam logic [WORD_BITS-1:0] VT_RESET = WORD_BITS'(64'd1 << (FRAC_BITS - 1));
    localparam logic [VA_BITS-1:0]   VA_RESET = VA_BITS'(64'd10 << FRAC_BITS);
    localparam logic [K_BITS-1:0]    K_RESET  =
        K_BITS'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

    // Sequencer to shared unit
    typedef struct packed {
        logic start;
        logic op;
    } unit_ctl_t;

    // Shared unit to sequencer
    typedef struct packed {
        logic done;
        logic clip;
    } unit_sts_t;

    typedef struct packed {
        logic  clip;
        word_t value;
    } sat_word_t;

    // a + b clipped to the word range
    function automatic sat_word_t sat_add(input word_t a, input word_t b);
        logic [WORD_BITS:0] d;
        sat_word_t r;
        d = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        r.clip = (d[WORD_BITS] != d[WORD_BITS-1]);
        if (r.clip)
        begin
            r.value = d[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end
        else
        begin
            r.value = d[WORD_BITS-1:0];
        end
        return r;
    endfunction

    // a - b clipped to the word range
    function automatic sat_word_t sat_sub(input word_t a, input word_t b);
        logic [WORD_BITS:0] d;
        sat_word_t r;
        d = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        r.clip = (d[WORD_BITS] != d[WORD_BITS-1]);
        if (r.clip)
        begin
            r.value = d[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end
        else
        begin
            r.value = d[WORD_BITS-1:0];
        end
        return r;
    endfunction

    // v / 2 truncated toward zero
    function automatic word_t half_toward_zero(input word_t v);
        word_t adj;
        adj = v + word_t'({{(WORD_BITS-1){1'b0}}, v[WORD_BITS-1]});
        return adj >>> 1;
    endfunction

    // Absolute value as an unsigned word (the most negative word maps to 2^(W-1))
    function automatic logic [WORD_BITS-1:0] magnitude(input word_t v);
        logic [WORD_BITS-1:0] u;
        u = v;
        return u[WORD_BITS-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

@@ hdl/pmce_ifs.sv @@
// ----------------------------------------------------------------------------
// pmce channel interfaces
// Valid/ready channels for the voltage samples and the companion results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pmce_sample_if;
    logic                  valid;
    logic                  ready;
    logic                  mode;
    pmce_pkg::word_t       v_source_gate;
    pmce_pkg::word_t       v_source_drain;

    modport source (output valid, mode, v_source_gate, v_source_drain, input ready);
    modport sink   (input valid, mode, v_source_gate, v_source_drain, output ready);
endinterface

interface pmce_result_if;
    logic                  valid;
    logic                  ready;
    pmce_pkg::word_t       delta_transconductance;
    pmce_pkg::word_t       delta_output_conductance;
    pmce_pkg::word_t       delta_equiv_current;
    logic [1:0]            region;
    logic                  saturated;

    modport source (output valid, delta_transconductance, delta_output_conductance,
                    delta_equiv_current, region, saturated, input ready);
    modport sink   (input valid, delta_transconductance, delta_output_conductance,
                    delta_equiv_current, region, saturated, output ready);
endinterface

@@ hdl/pmce_unit.sv @@
// ----------------------------------------------------------------------------
// pmce_unit
// Shared iterative arithmetic unit: saturating fixed point multiply in
// 16-bit digit steps, and restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmce_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  pmce_pkg::unit_ctl_t ctl,
    input  pmce_pkg::word_t     opa,
    input  pmce_pkg::word_t     opb,
    output pmce_pkg::unit_sts_t sts,
    output pmce_pkg::word_t     result
);
    import pmce_pkg::*;

    localparam int MAG_BITS = ACC_BITS - FRAC_BITS;

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;
    localparam logic [1:0] U_FIN  = 2'd3;

    localparam logic [MAG_BITS-1:0] LIM_NEG = MAG_BITS'(1) << (WORD_BITS - 1);
    localparam logic [MAG_BITS-1:0] LIM_POS = LIM_NEG - MAG_BITS'(1);

    logic [1:0]                      state_reg, state_next;
    logic [CNT_BITS-1:0]             cnt_reg, cnt_next;
    logic                            op_reg, op_next;
    logic                            neg_reg, neg_next;
    logic                            ovf_reg, ovf_next;
    logic [WORD_BITS-1:0]            x_reg, x_next;
    logic [WORD_BITS-1:0]            y_reg, y_next;
    logic [ACC_BITS-1:0]             acc_reg, acc_next;
    logic                            done_reg, done_next;
    logic                            flag_reg, flag_next;
    word_t                           res_reg, res_next;

    logic [WORD_BITS+MUL_DIGIT-1:0]  pp;
    logic [WORD_BITS:0]              trial;
    logic [MAG_BITS-1:0]             mag;
    logic [MAG_BITS-1:0]             lim;
    logic                            mul_clip;
    logic [WORD_BITS-1:0]            sat_mag;
    logic [ACC_BITS-1:0]             div_num;
    logic                            div_ovf;

    // Digit product, division trial subtract and product clipping
    always_comb
    begin
        pp       = x_reg * y_reg[WORD_BITS-1 -: MUL_DIGIT];
        trial    = {1'b0, acc_reg[ACC_BITS-3 : WORD_BITS-2]} - {1'b0, y_reg};
        mag      = acc_reg[ACC_BITS-1:FRAC_BITS];
        lim      = neg_reg ? LIM_NEG : LIM_POS;
        mul_clip = (mag > lim);
        sat_mag  = mul_clip ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
        div_num  = ACC_BITS'({opa, {FRAC_BITS{1'b0}}});
        div_ovf  = (div_num >= ACC_BITS'({opb, {(WORD_BITS-1){1'b0}}}));
    end

    // Step sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        flag_next  = flag_reg;
        res_next   = res_reg;

        unique case (state_reg)
            U_IDLE:
            begin
                if (ctl.start)
                begin
                    op_next  = ctl.op;
                    cnt_next = '0;
                    if (ctl.op == OP_MUL)
                    begin
                        x_next     = magnitude(opa);
                        y_next     = magnitude(opb);
                        neg_next   = opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
                        acc_next   = '0;
                        state_next = U_MUL;
                    end
                    else
                    begin
                        y_next     = opb;
                        acc_next   = div_num;
                        ovf_next   = div_ovf;
                        state_next = div_ovf ? U_FIN : U_DIV;
                    end
                end
            end

            U_MUL:
            begin
                // Most significant digit first: shift and accumulate
                acc_next = (acc_reg << MUL_DIGIT) + ACC_BITS'(pp);
                y_next   = y_reg << MUL_DIGIT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(MUL_STEPS - 1))
                begin
                    state_next = U_FIN;
                end
            end

            U_DIV:
            begin
                // Shift the partial remainder in by one bit, keep it if it fits
                if (!trial[WORD_BITS])
                begin
                    acc_next = {1'b0, trial[WORD_BITS-1:0], acc_reg[WORD_BITS-3:0], 1'b1};
                end
                else
                begin
                    acc_next = {1'b0, acc_reg[ACC_BITS-3 : WORD_BITS-2],
                                acc_reg[WORD_BITS-3:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DIV_STEPS - 1))
                begin
                    state_next = U_FIN;
                end
            end

            U_FIN:
            begin
                done_next  = 1'b1;
                state_next = U_IDLE;
                if (op_reg == OP_MUL)
                begin
                    flag_next = mul_clip;
                    res_next  = neg_reg ? word_t'(~sat_mag + 1'b1) : word_t'(sat_mag);
                end
                else
                begin
                    flag_next = ovf_reg;
                    res_next  = ovf_reg ? WORD_MAX
                                        : word_t'({1'b0, acc_reg[WORD_BITS-2:0]});
                end
            end

            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        op_reg   <= op_next;
        neg_reg  <= neg_next;
        ovf_reg  <= ovf_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        flag_reg <= flag_next;
        res_reg  <= res_next;
    end

    assign sts.done = done_reg;
    assign sts.clip = flag_reg;
    assign result   = res_reg;

endmodule

@@ hdl/pmos_level1_companion_eval_core.sv @@
// ----------------------------------------------------------------------------
// pmos_level1_companion_eval_core
// Cutoff skips the shared unit; triode uses six products, and saturation
// four products and a 47-step division, all on the one shared unit.
// Samples are taken only while idle, so a new sample is not accepted until
// the result of the last one is loaded; it can be taken in the cycle after
// that load. Reset loads the register defaults and clears the previous gm,
// go and Ieq to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmos_level1_companion_eval_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    pmce_sample_if.sink                           sample,
    pmce_result_if.source                         result,
    input  logic                                  cfg_en,
    input  logic [pmce_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pmce_pkg::CFG_BITS-1:0]         cfg_data
);
    import pmce_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_SAT_GM = 4'd2;
    localparam logic [3:0] S_SAT_I  = 4'd3;
    localparam logic [3:0] S_SAT_GO = 4'd4;
    localparam logic [3:0] S_TRI_GM = 4'd5;
    localparam logic [3:0] S_TRI_GO = 4'd6;
    localparam logic [3:0] S_TRI_T  = 4'd7;
    localparam logic [3:0] S_TRI_I  = 4'd8;
    localparam logic [3:0] S_IEQ1   = 4'd9;
    localparam logic [3:0] S_IEQ2   = 4'd10;
    localparam logic [3:0] S_DELTA  = 4'd11;

    logic [3:0]          state_reg, state_next;

    word_t               vt_reg;
    logic [VA_BITS-1:0]  va_reg;
    logic [K_BITS-1:0]   k_reg;

    word_t               last_gm_reg, last_gm_next;
    word_t               last_go_reg, last_go_next;
    word_t               last_ieq_reg, last_ieq_next;

    word_t               vsg_reg, vsg_next;
    word_t               vsd_reg, vsd_next;
    word_t               ov_reg, ov_next;
    word_t               gm_reg, gm_next;
    word_t               go_reg, go_next;
    word_t               cur_reg, cur_next;
    word_t               ieq_reg, ieq_next;
    logic                clip_reg, clip_next;
    logic [1:0]          region_reg, region_next;

    word_t               opa_reg, opa_next;
    word_t               opb_reg, opb_next;
    unit_ctl_t           ctl_reg, ctl_next;

    logic                out_valid_reg, out_valid_next;
    word_t               out_dgm_reg, out_dgm_next;
    word_t               out_dgo_reg, out_dgo_next;
    word_t               out_dieq_reg, out_dieq_next;
    logic [1:0]          out_region_reg, out_region_next;
    logic                out_sat_reg, out_sat_next;

    unit_sts_t           unit_sts;
    word_t               unit_res;

    logic                accept;
    word_t               k_word;
    word_t               va_word;
    sat_word_t           start_s;
    sat_word_t           ov_s;
    sat_word_t           tri_go_s;
    sat_word_t           tri_t_s;
    sat_word_t           ieq1_s;
    sat_word_t           ieq2_s;
    sat_word_t           dgm_s;
    sat_word_t           dgo_s;
    sat_word_t           dieq_s;

    // Shared multiply / divide unit
    pmce_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_reg),
        .opa    (opa_reg),
        .opb    (opb_reg),
        .sts    (unit_sts),
        .result (unit_res)
    );

    // Request handshake and operand forms
    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign k_word       = word_t'({1'b0, k_reg});
    assign va_word      = word_t'({1'b0, va_reg});

    // Saturating adds and subtracts used along the sequence
    assign start_s  = sat_add(vt_reg, ONE_TENTH);
    assign ov_s     = sat_sub(vsg_reg, vt_reg);
    assign tri_go_s = sat_sub(ov_reg, vsd_reg);
    assign tri_t_s  = sat_sub(ov_reg, half_toward_zero(vsd_reg));
    assign ieq1_s   = sat_sub(cur_reg, unit_res);
    assign ieq2_s   = sat_sub(ieq_reg, unit_res);
    assign dgm_s    = sat_sub(gm_reg, last_gm_reg);
    assign dgo_s    = sat_sub(go_reg, last_go_reg);
    assign dieq_s   = sat_sub(ieq_reg, last_ieq_reg);

    // Evaluation sequencer
    always_comb
    begin
        state_next      = state_reg;
        last_gm_next    = last_gm_reg;
        last_go_next    = last_go_reg;
        last_ieq_next   = last_ieq_reg;
        vsg_next        = vsg_reg;
        vsd_next        = vsd_reg;
        ov_next         = ov_reg;
        gm_next         = gm_reg;
        go_next         = go_reg;
        cur_next        = cur_reg;
        ieq_next        = ieq_reg;
        clip_next       = clip_reg | (unit_sts.done & unit_sts.clip);
        region_next     = region_reg;
        opa_next        = opa_reg;
        opb_next        = opb_reg;
        ctl_next.start  = 1'b0;
        ctl_next.op     = ctl_reg.op;
        out_dgm_next    = out_dgm_reg;
        out_dgo_next    = out_dgo_reg;
        out_dieq_next   = out_dieq_reg;
        out_region_next = out_region_reg;
        out_sat_next    = out_sat_reg;

        // Drop the result once taken
        out_valid_next = out_valid_reg && !result.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sample.mode)
                    begin
                        vsg_next  = start_s.value;
                        vsd_next  = start_s.value;
                        clip_next = start_s.clip;
                    end
                    else
                    begin
                        vsg_next  = sample.v_source_gate;
                        vsd_next  = sample.v_source_drain;
                        clip_next = 1'b0;
                    end
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                ov_next   = ov_s.value;
                clip_next = clip_reg | ov_s.clip;
                if (vsg_reg < vt_reg)
                begin
                    region_next = REGION_CUTOFF;
                    gm_next     = '0;
                    go_next     = '0;
                    ieq_next    = '0;
                    state_next  = S_DELTA;
                end
                else if ($signed(ov_s.value) < vsd_reg)
                begin
                    region_next    = REGION_SATURATION;
                    opa_next       = k_word;
                    opb_next       = ov_s.value;
                    ctl_next.start = 1'b1;
                    ctl_next.op    = OP_MUL;
                    state_next     = S_SAT_GM;
                end
                else
                begin
                    region_next    = REGION_TRIODE;
                    opa_next       = k_word;
                    opb_next       = vsd_reg;
                    ctl_next.start = 1'b1;
                    ctl_next.op    = OP_MUL;
                    state_next     = S_TRI_GM;
                end
            end

            // Saturation: gm = K*ov, I = gm*ov/2, go = I/Va
            S_SAT_GM:
            begin
                if (unit_sts.done)
                begin
                    gm_next        = unit_res;
                    opa_next       = unit_res;
                    opb_next       = ov_reg;
                    ctl_next.start = 1'b1;
                    ctl_next.op    = OP_MUL;
                    state_next     = S_SAT_I;
                end
            end

            S_SAT_I:
            begin
                if (unit_sts.done)
                begin
                    cur_next       = half_toward_zero(unit_res);
                    opa_next       = half_toward_zero(unit_res);
                    opb_next       = va_word;
                    ctl_next.start = 1'b1;
                    ctl_next.op    = OP_DIV;
                    state_next     = S_SAT_GO;
                end
            end

            S_SAT_GO:
            begin
                if (unit_sts.done)
                begin
                    go_next        = unit_res;
                    opa_next       = gm_reg;
                    opb_next       = vsg_reg;
                    ctl_next.start = 1'b1;
                    ctl_next.op    = OP_MUL;
                    state_next     = S_IEQ1;
                end
            end

            // Triode: gm = K*vSD, go = K*(ov-vSD), I = K*(ov-vSD/2)*vSD
            S_TRI_GM:
            begin
                if (unit_sts.done)
                begin
                    gm_next        = unit_res;
                    clip_next      = clip_reg | unit_sts.clip | tri_go_s.clip;
                    opa_next       = k_word;
                    opb_next       = tri_go_s.value;
                    ctl_next.start = 1'b1;
                    ctl_next.op    = OP_MUL;
                    state_next     = S_TRI_GO;
                end
            end

            S_TRI_GO:
            begin
                if (unit_sts.done)
                begin
                    go_next        = unit_res;
                    clip_next      = clip_reg | unit_sts.clip | tri_t_s.clip;
                    opa_next       = k_word;
                    opb_next       = tri_t_s.value;
                    ctl_next.start = 1'b1;
                    ctl_next.op    = OP_MUL;
                    state_next     = S_TRI_T;
                end
            end

            S_TRI_T:
            begin
                if (unit_sts.done)
                begin
                    opa_next       = unit_res;
                    opb_next       = vsd_reg;
                    ctl_next.start = 1'b1;
                    ctl_next.op    = OP_MUL;
                    state_next     = S_TRI_I;
                end
            end

            S_TRI_I:
            begin
                if (unit_sts.done)
                begin
                    cur_next       = unit_res;
                    opa_next       = gm_reg;
                    opb_next       = vsg_reg;
                    ctl_next.start = 1'b1;
                    ctl_next.op    = OP_MUL;
                    state_next     = S_IEQ1;
                end
            end

            // Ieq = I - gm*vSG - go*vSD
            S_IEQ1:
            begin
                if (unit_sts.done)
                begin
                    ieq_next       = ieq1_s.value;
                    clip_next      = clip_reg | unit_sts.clip | ieq1_s.clip;
                    opa_next       = go_reg;
                    opb_next       = vsd_reg;
                    ctl_next.start = 1'b1;
                    ctl_next.op    = OP_MUL;
                    state_next     = S_IEQ2;
                end
            end

            S_IEQ2:
            begin
                if (unit_sts.done)
                begin
                    ieq_next   = ieq2_s.value;
                    clip_next  = clip_reg | unit_sts.clip | ieq2_s.clip;
                    state_next = S_DELTA;
                end
            end

            // Hold until the output register is free, then load and advance history
            S_DELTA:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_dgm_next    = dgm_s.value;
                    out_dgo_next    = dgo_s.value;
                    out_dieq_next   = dieq_s.value;
                    out_region_next = region_reg;
                    out_sat_next    = clip_reg | dgm_s.clip | dgo_s.clip | dieq_s.clip;
                    last_gm_next    = gm_reg;
                    last_go_next    = go_reg;
                    last_ieq_next   = ieq_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, configuration and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctl_reg       <= '0;
            out_valid_reg <= 1'b0;
            vt_reg        <= VT_RESET;
            va_reg        <= VA_RESET;
            k_reg         <= K_RESET;
            last_gm_reg   <= '0;
            last_go_reg   <= '0;
            last_ieq_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ctl_reg       <= ctl_next;
            out_valid_reg <= out_valid_next;
            last_gm_reg   <= last_gm_next;
            last_go_reg   <= last_go_next;
            last_ieq_reg  <= last_ieq_next;
            if (cfg_en)
            begin
                priority case (cfg_index)
                    REG_THRESHOLD: vt_reg <= cfg_data[WORD_BITS-1:0];
                    REG_EARLY:     va_reg <= cfg_data[VA_BITS-1:0];
                    REG_GAIN:      k_reg  <= cfg_data[K_BITS-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // Working values and output payload
    always_ff @(posedge clk)
    begin
        vsg_reg        <= vsg_next;
        vsd_reg        <= vsd_next;
        ov_reg         <= ov_next;
        gm_reg         <= gm_next;
        go_reg         <= go_next;
        cur_reg        <= cur_next;
        ieq_reg        <= ieq_next;
        clip_reg       <= clip_next;
        region_reg     <= region_next;
        opa_reg        <= opa_next;
        opb_reg        <= opb_next;
        out_dgm_reg    <= out_dgm_next;
        out_dgo_reg    <= out_dgo_next;
        out_dieq_reg   <= out_dieq_next;
        out_region_reg <= out_region_next;
        out_sat_reg    <= out_sat_next;
    end

    assign result.valid                    = out_valid_reg;
    assign result.delta_transconductance   = out_dgm_reg;
    assign result.delta_output_conductance = out_dgo_reg;
    assign result.delta_equiv_current      = out_dieq_reg;
    assign result.region                   = out_region_reg;
    assign result.saturated                = out_sat_reg;

endmodule

@@ hdl/pmce_checker.sv @@
// ----------------------------------------------------------------------------
// pmce_checker
// Port-level assertions for the PMOS level-1 companion evaluator, bound to
// the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pmos_level1_companion_eval_core_macros.svh"

module pmce_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic            out_valid,
    input  logic            out_ready,
    input  pmce_pkg::word_t out_dgm,
    input  pmce_pkg::word_t out_dgo,
    input  pmce_pkg::word_t out_dieq,
    input  logic [1:0]      out_region,
    input  logic            out_saturated
);
    // Hold a stalled result with its payload
    `PMCE_CHECK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_dgm) && $stable(out_dgo) && $stable(out_dieq) && $stable(out_region) && $stable(out_saturated))

    // One request at a time: busy right after an accept
    `PMCE_CHECK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // A new result only appears out of a busy evaluation
    `PMCE_CHECK_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), $past(!in_ready))

    // No result in the cycle right after an accept
    `PMCE_CHECK_NEXT(a_no_early_result, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind pmos_level1_companion_eval_core pmce_checker u_pmce_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_dgm       (result.delta_transconductance),
    .out_dgo       (result.delta_output_conductance),
    .out_dieq      (result.delta_equiv_current),
    .out_region    (result.region),
    .out_saturated (result.saturated)
);
